>>> rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the thread scheduler RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> rtl/fts_pkg.sv
// -----------------------------------------------------------------------------
// fts_pkg
// Types and constants shared by the thread scheduler modules.
// -----------------------------------------------------------------------------
`default_nettype none

package fts_pkg;

   localparam int MAX_THREADS = 16;
   localparam int ID_W        = $clog2(MAX_THREADS);
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);

   localparam int REQ_W = 8;
   localparam int RSP_W = 16;

   typedef enum logic [1:0] {
      ACT_CREATE = 2'd0,
      ACT_YIELD  = 2'd1,
      ACT_JOIN   = 2'd2,
      ACT_EXIT   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      TS_UNUSED  = 3'd0,
      TS_READY   = 3'd1,
      TS_RUNNING = 3'd2,
      TS_BLOCKED = 3'd3,
      TS_DONE    = 3'd4
   } tstate_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_RESOLVE
   } state_type;

   // One queue entry: a thread id and, in the wait queue, the id it waits for.
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] tag;
   } entry_type;

   // Command to a queue chain for one cycle.
   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type data;
   } chain_op_type;

endpackage

`default_nettype wire

>>> rtl/fts_cell.sv
// -----------------------------------------------------------------------------
// fts_cell
// One storage cell of a queue chain: shifts from its neighbor or loads new data.
// -----------------------------------------------------------------------------
`default_nettype none

module fts_cell (
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire fts_pkg::entry_type shift_data,
   input  wire logic              load_en,
   input  wire fts_pkg::entry_type load_data,
   output fts_pkg::entry_type     entry
);
   import fts_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A load lands after the shift of the same cycle, so it takes priority.
   always_comb begin
      priority if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = shift_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> rtl/fts_chain.sv
// -----------------------------------------------------------------------------
// fts_chain
// FIFO built from a row of cells; a pop shifts every cell toward the head.
// -----------------------------------------------------------------------------
`default_nettype none

module fts_chain (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fts_pkg::chain_op_type op,
   output fts_pkg::entry_type        head,
   output logic [fts_pkg::CNT_W-1:0] count
);
   import fts_pkg::*;
   `include "assert_macros.svh"

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] wr_pos;
   logic             push_eff;

   entry_type cell_q [MAX_THREADS];
   entry_type nb_q   [MAX_THREADS];

   // A push into a full queue is dropped unless a pop frees a slot.
   assign push_eff = op.push && (op.pop || (count_ff != CNT_W'(MAX_THREADS)));
   assign wr_pos   = op.pop ? (count_ff - CNT_W'(1)) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (push_eff && !op.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.pop && !push_eff) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      if (i == MAX_THREADS - 1) begin : g_last
         assign nb_q[i] = cell_q[i];
      end else begin : g_mid
         assign nb_q[i] = cell_q[i+1];
      end

      fts_cell u_cell (
         .clock      (clock),
         .shift_en   (op.pop),
         .shift_data (nb_q[i]),
         .load_en    (push_eff && (wr_pos == CNT_W'(i))),
         .load_data  (op.data),
         .entry      (cell_q[i])
      );
   end

   assign head  = cell_q[0];
   assign count = count_ff;

   `ASSERT_NEVER(a_pop_empty, op.pop && (count_ff == '0), "pop from an empty queue chain")
   `ASSERT_CLK(a_count_bound, count_ff <= CNT_W'(MAX_THREADS), "queue chain count overflow")

endmodule

`default_nettype wire

>>> rtl/fifo_thread_scheduler_top.sv
// -----------------------------------------------------------------------------
// fifo_thread_scheduler_top
// Cooperative FIFO thread scheduler with create, yield, join and exit events.
// -----------------------------------------------------------------------------
//
//   Channel   Direction   Transaction
//   -------   ---------   ----------------------------------------------------
//   req_*     in          one scheduling event (action, target_thread)
//   rsp_*     out         one result per event (status, created id,
//                         running_thread, switched)
//
// A create, yield or join commits in S_EXEC, which loads its result into the
// output register and raises rsp_tvalid once that register is free. An exit by
// a thread other than main walks the wait queue one entry per cycle in S_SCAN,
// covering every blocked thread (at most MAX_THREADS - 2), then resolves in S_RESOLVE.
// A new event is accepted as soon as the scheduler is back in idle, even while
// the previous result still sits unclaimed in the output register; a stalled
// output register holds the scheduler before it commits the next event.
// Reset is synchronous: main runs, all other threads are unused, queues empty.
// -----------------------------------------------------------------------------
`default_nettype none

module fifo_thread_scheduler_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // action [1:0], target_thread [5:2], zero [7:6]
   input  wire logic [fts_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // status [0], created id [4:1], running_thread [8:5], switched [9], zero [15:10]
   output logic [fts_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready
);
   import fts_pkg::*;
   `include "assert_macros.svh"

   // Control state.
   state_type        state_ff,     state_in;
   logic [ID_W-1:0]  cur_ff,       cur_in;
   logic [CNT_W-1:0] nfid_ff,      nfid_in;
   tstate_type       ts_ff [MAX_THREADS];
   tstate_type       ts_in [MAX_THREADS];
   logic             found_ff,     found_in;
   logic [ID_W-1:0]  found_id_ff,  found_id_in;
   logic [CNT_W-1:0] scan_cnt_ff,  scan_cnt_in;
   logic [CNT_W-1:0] scan_len_ff,  scan_len_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Latched event and result payload.
   action_type       act_ff;
   logic [ID_W-1:0]  tgt_ff;
   logic [RSP_W-1:0] rsp_data_ff,  rsp_data_in;

   // Queue chains: ready threads in FIFO order, blocked threads in blocking order.
   chain_op_type     rdy_op, wt_op;
   entry_type        rdy_head, wt_head;
   logic [CNT_W-1:0] rdy_count, wt_count;

   logic             out_free;
   logic             accept;
   logic             load_rsp;
   logic             rsp_status;
   logic [ID_W-1:0]  rsp_new;
   logic             run_en;
   logic [ID_W-1:0]  run_id;
   logic             yield_req;
   logic             scan_match;
   tstate_type       tgt_state;

   fts_chain u_ready (
      .clock (clock),
      .reset (reset),
      .op    (rdy_op),
      .head  (rdy_head),
      .count (rdy_count)
   );

   fts_chain u_wait (
      .clock (clock),
      .reset (reset),
      .op    (wt_op),
      .head  (wt_head),
      .count (wt_count)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign tgt_state  = ts_ff[tgt_ff];
   assign scan_match = (wt_head.tag == cur_ff) && !found_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      nfid_in     = nfid_ff;
      ts_in       = ts_ff;
      found_in    = found_ff;
      found_id_in = found_id_ff;
      scan_cnt_in = scan_cnt_ff;
      scan_len_in = scan_len_ff;
      rdy_op      = '0;
      wt_op       = '0;
      load_rsp    = 1'b0;
      rsp_status  = 1'b0;
      rsp_new     = '0;
      run_en      = 1'b0;
      run_id      = '0;
      yield_req   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end

         // Every event but a non-main exit commits here, once the output
         // register can take its result.
         S_EXEC: begin
            if (out_free) begin
               unique case (act_ff)
                  ACT_CREATE: begin
                     if (nfid_ff == CNT_W'(MAX_THREADS)) begin
                        rsp_status = 1'b1;
                     end else begin
                        rsp_new              = nfid_ff[ID_W-1:0];
                        nfid_in              = nfid_ff + CNT_W'(1);
                        ts_in[rsp_new]       = TS_READY;
                        rdy_op.push          = 1'b1;
                        rdy_op.data.id       = rsp_new;
                     end
                  end
                  ACT_YIELD: begin
                     yield_req = 1'b1;
                  end
                  ACT_JOIN: begin
                     priority if (tgt_state == TS_DONE) begin
                        rsp_status = 1'b0;
                     end else if ((tgt_ff == '0) || (tgt_ff == cur_ff) ||
                                  (tgt_state != TS_READY)) begin
                        // Main still gives up the processor on a failed join.
                        yield_req  = (cur_ff == '0);
                        rsp_status = 1'b1;
                     end else if (cur_ff == '0) begin
                        yield_req = 1'b1;
                     end else begin
                        wt_op.push     = 1'b1;
                        wt_op.data.id  = cur_ff;
                        wt_op.data.tag = tgt_ff;
                        ts_in[cur_ff]  = TS_BLOCKED;
                        if (rdy_count == '0) begin
                           rsp_status = 1'b1;
                        end else begin
                           rdy_op.pop = 1'b1;
                           run_en     = 1'b1;
                           run_id     = rdy_head.id;
                        end
                     end
                  end
                  ACT_EXIT: begin
                     if (cur_ff == '0) begin
                        rsp_status = 1'b1;
                     end else begin
                        ts_in[cur_ff] = TS_DONE;
                        found_in      = 1'b0;
                        scan_cnt_in   = '0;
                        scan_len_in   = wt_count;
                     end
                  end
                  default: begin
                  end
               endcase

               // Yield: the ready head runs; main is marked ready but not queued.
               if (yield_req && (rdy_count != '0)) begin
                  rdy_op.pop     = 1'b1;
                  ts_in[cur_ff]  = TS_READY;
                  run_en         = 1'b1;
                  run_id         = rdy_head.id;
                  if (cur_ff != '0) begin
                     rdy_op.push    = 1'b1;
                     rdy_op.data.id = cur_ff;
                  end
               end

               if ((act_ff == ACT_EXIT) && (cur_ff != '0)) begin
                  state_in = S_SCAN;
               end else begin
                  load_rsp = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         // Rotate the wait queue once: every entry leaves the head and
         // re-enters at the tail, except the earliest waiter on the exiting
         // thread, which is dropped and remembered.
         S_SCAN: begin
            if (scan_cnt_ff == scan_len_ff) begin
               state_in = S_RESOLVE;
            end else begin
               wt_op.pop   = 1'b1;
               wt_op.push  = !scan_match;
               wt_op.data  = wt_head;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               if (scan_match) begin
                  found_in    = 1'b1;
                  found_id_in = wt_head.id;
               end
            end
         end

         S_RESOLVE: begin
            if (out_free) begin
               run_en = 1'b1;
               priority if (found_ff) begin
                  run_id = found_id_ff;
               end else if (rdy_count != '0) begin
                  rdy_op.pop = 1'b1;
                  run_id     = rdy_head.id;
               end else begin
                  run_id = '0;
               end
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (run_en) begin
         ts_in[run_id] = TS_RUNNING;
         cur_in        = run_id;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_W - 2 - 2 * ID_W){1'b0}}, (cur_in != cur_ff), cur_in,
                         rsp_new, rsp_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         nfid_ff      <= CNT_W'(1);
         found_ff     <= 1'b0;
         scan_cnt_ff  <= '0;
         scan_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_THREADS; i++) begin
            ts_ff[i] <= (i == 0) ? TS_RUNNING : TS_UNUSED;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         nfid_ff      <= nfid_in;
         found_ff     <= found_in;
         scan_cnt_ff  <= scan_cnt_in;
         scan_len_ff  <= scan_len_in;
         rsp_valid_ff <= rsp_valid_in;
         ts_ff        <= ts_in;
      end
   end

   always_ff @(posedge clock) begin
      found_id_ff <= found_id_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         act_ff <= action_type'(req_tdata[1:0]);
         tgt_ff <= req_tdata[2 +: ID_W];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_CLK(a_cur_running, (state_ff == S_IDLE) |-> (ts_ff[cur_ff] == TS_RUNNING), "not running")
   `ASSERT_CLK(a_accept_exec, accept |=> (state_ff == S_EXEC), "accepted event did not start")

endmodule

`default_nettype wire
